// File: src/mstw_pkg.sv
// ----------------------------------------------------------------------------
// mstw_pkg : shared types and constants of the spanning tree weight block
// Transfer structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mstw_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 1024;
  localparam int unsigned DEF_MAX_EDGES    = 4096;

  localparam int unsigned VW   = 10;
  localparam int unsigned WW   = 16;
  localparam int unsigned SW   = 28;
  localparam int unsigned CW   = WW + 1;
  localparam int unsigned CFGW = 11;

  localparam logic [CW-1:0] LINK_INF = 17'h10000;
  localparam logic [SW-1:0] SUM_MAX  = 28'hFFFFFFF;

  typedef struct packed {
    logic [VW-1:0] from_vertex;
    logic [VW-1:0] to_vertex;
    logic [WW-1:0] edge_weight;
    logic          last_edge;
  } mstw_in_t;

  typedef struct packed {
    logic [SW-1:0] tree_weight;
    logic [SW-1:0] total_weight;
    logic [SW-1:0] saved_weight;
    logic          connected;
  } mstw_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_END,
    ST_DONE,
    ST_OUT
  } mstw_state_t;

  typedef struct packed {
    logic load;
    logic init_start;
    logic init_step;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic relax_start;
    logic relax_step;
    logic finish;
    logic clear;
  } mstw_cmd_t;

  typedef struct packed {
    logic init_last;
    logic scan_last;
    logic found;
    logic relax_last;
    logic no_edges;
  } mstw_sts_t;

endpackage

// File: src/minimum_spanning_tree_weight.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight : Prim spanning tree weight over a loaded graph
//
//   channel  | ports                     | moves
//   ---------+---------------------------+-------------------------------
//   input    | in_valid/in_ready/in_data | one edge per transfer
//   result   | out_valid/out_ready/...   | one result per last edge
//   config   | cfg_we/cfg_wdata          | vertex count, no handshake
//
// Edges load at one per cycle. After the last edge the walk rewrites the
// vertex memories, then each step sweeps the link-cost memory one vertex
// a cycle, then the edge store one edge a cycle. Input stays stalled until
// the result transfers. The result register holds while out_ready is low.
// Reset clears control, the edge count and the edge weight sum; the vertex
// memories are rewritten at the start of every walk.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight #(
  parameter int unsigned MAX_VERTICES = mstw_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = mstw_pkg::DEF_MAX_EDGES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mstw_pkg::mstw_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mstw_pkg::mstw_out_t       out_data,
  input  logic                      cfg_we,
  input  logic [mstw_pkg::CFGW-1:0] cfg_wdata
);
  import mstw_pkg::*;

  mstw_cmd_t         cmd;
  mstw_sts_t         sts;
  logic [CFGW-1:0]   vcount_r;

  // vertex count register; the user writes it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= CFGW'(1);
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  mstw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_edge (in_data.last_edge),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mstw_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_data),
    .vcount  (vcount_r),
    .result  (out_data)
  );

`ifndef SYNTHESIS
  // never ready for input while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");
  // a last edge transfer leads out of the load phase
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_edge) |=> !in_ready)
    else $error("input still open after last edge");
  // the result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
`endif

endmodule

// File: src/mstw_datapath.sv
// ----------------------------------------------------------------------------
// mstw_datapath : edge store, link cost memory and the sums
// Sweeps vertices to pick the cheapest link, sweeps edges to relax.
// ----------------------------------------------------------------------------
module mstw_datapath #(
  parameter int unsigned MAX_VERTICES = mstw_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = mstw_pkg::DEF_MAX_EDGES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mstw_pkg::mstw_cmd_t          cmd,
  output mstw_pkg::mstw_sts_t          sts,
  input  mstw_pkg::mstw_in_t           in_item,
  input  logic [mstw_pkg::CFGW-1:0]    vcount,
  output mstw_pkg::mstw_out_t          result
);
  import mstw_pkg::*;

  localparam int unsigned AV = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AE = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NV = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NE = $clog2(MAX_EDGES + 1);
  localparam int unsigned EW = 2 * VW + WW;

  logic [EW-1:0]  edge_mem [MAX_EDGES];
  logic [CW-1:0]  cost_mem [MAX_VERTICES];
  logic           tree_mem [MAX_VERTICES];

  logic [NE-1:0]  ecount_r;
  logic [SW-1:0]  wsum_r;
  logic [NV-1:0]  n_r;
  logic [NV-1:0]  vidx_r;
  logic [NE-1:0]  eidx_r;
  logic [CW-1:0]  best_cost_r;
  logic [NV-1:0]  best_v_r;
  logic [NV-1:0]  pick_r;
  logic [NV-1:0]  reached_r;
  logic [SW+1:0]  tree_r;
  logic           scan_vld_r;
  logic [AV-1:0]  scan_v_r;
  logic [CW-1:0]  rd_cost_r;
  logic           rd_tree_r;
  logic           rel_vld_r;
  logic [EW-1:0]  rd_edge_r;
  logic           other_vld_r;
  logic [AV-1:0]  other_r;
  logic [WW-1:0]  other_w_r;
  logic [CW-1:0]  oth_cost_r;
  logic           oth_tree_r;
  logic           cmp_vld_r;
  logic [AV-1:0]  cmp_v_r;
  logic [WW-1:0]  cmp_w_r;
  logic           upd_vld_r;
  logic [AV-1:0]  upd_v_r;
  logic [WW-1:0]  upd_w_r;
  mstw_out_t      result_r;

  logic [NV-1:0]  n_nxt;
  logic [SW:0]    wsum_add;
  logic [VW-1:0]  ea, eb;
  logic [WW-1:0]  ew;
  logic [SW-1:0]  tree_sat;
  logic           rel_in;
  logic           relax_hit;

  always_comb begin
    n_nxt = vcount[NV-1:0];
    if (vcount == '0) n_nxt = NV'(1);
    if ({21'd0, vcount} > 32'(MAX_VERTICES)) n_nxt = NV'(MAX_VERTICES);
  end

  assign wsum_add = {1'b0, wsum_r} + (SW+1)'(in_item.edge_weight);
  assign ea = rd_edge_r[EW-1 -: VW];
  assign eb = rd_edge_r[WW +: VW];
  assign ew = rd_edge_r[WW-1:0];
  assign tree_sat = (tree_r > (SW+2)'(SUM_MAX)) ? SUM_MAX : tree_r[SW-1:0];

  // both endpoints inside the vertex range
  assign rel_in = rel_vld_r && {1'b0, ea} < n_r && {1'b0, eb} < n_r;

  // the memory read may predate the previous write: that write to the same vertex
  // is taken from the last-write register instead
  assign relax_hit = cmp_vld_r && !oth_tree_r && {1'b0, cmp_w_r} < oth_cost_r &&
                     !(upd_vld_r && upd_v_r == cmp_v_r && upd_w_r <= cmp_w_r);

  // edge store
  always_ff @(posedge clk) begin
    if (cmd.load && ecount_r < NE'(MAX_EDGES))
      edge_mem[ecount_r[AE-1:0]] <= {in_item.from_vertex, in_item.to_vertex,
                                     in_item.edge_weight};
    rd_edge_r <= edge_mem[eidx_r[AE-1:0]];
  end

  // vertex memories: one write port, shared between init, pick and relax
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      cost_mem[vidx_r[AV-1:0]] <= (vidx_r == '0) ? '0 : LINK_INF;
      tree_mem[vidx_r[AV-1:0]] <= 1'b0;
    end else if (cmd.pick) begin
      tree_mem[best_v_r[AV-1:0]] <= 1'b1;
    end else if (relax_hit) begin
      cost_mem[cmp_v_r] <= {1'b0, cmp_w_r};
    end
    rd_cost_r  <= cost_mem[vidx_r[AV-1:0]];
    rd_tree_r  <= tree_mem[vidx_r[AV-1:0]];
    oth_cost_r <= cost_mem[other_r];
    oth_tree_r <= tree_mem[other_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r    <= '0;
      wsum_r      <= '0;
      vidx_r      <= '0;
      eidx_r      <= '0;
      scan_vld_r  <= 1'b0;
      rel_vld_r   <= 1'b0;
      other_vld_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      upd_vld_r   <= 1'b0;
    end else begin
      scan_vld_r  <= cmd.scan_step;
      scan_v_r    <= vidx_r[AV-1:0];
      rel_vld_r   <= cmd.relax_step;
      if (cmd.load && ecount_r < NE'(MAX_EDGES)) begin
        ecount_r <= ecount_r + NE'(1);
        wsum_r   <= wsum_add[SW] ? SUM_MAX : wsum_add[SW-1:0];
      end
      if (cmd.init_start) begin
        n_r       <= n_nxt;
        reached_r <= '0;
        tree_r    <= '0;
      end
      if (cmd.init_start || cmd.scan_start) vidx_r <= '0;
      else if (cmd.init_step || cmd.scan_step) vidx_r <= vidx_r + NV'(1);
      if (cmd.scan_start) begin
        best_cost_r <= LINK_INF;
        best_v_r    <= n_r;
      end
      // compare stage: strict less keeps the lowest index on ties
      if (scan_vld_r && !rd_tree_r && rd_cost_r < best_cost_r) begin
        best_cost_r <= rd_cost_r;
        best_v_r    <= NV'(scan_v_r);
      end
      if (cmd.pick) begin
        pick_r    <= best_v_r;
        reached_r <= reached_r + NV'(1);
        tree_r    <= tree_r + (SW+2)'(best_cost_r);
      end
      if (cmd.relax_start) eidx_r <= '0;
      if (cmd.relax_step)  eidx_r <= eidx_r + NE'(1);
      // relax pipeline: edge read, endpoint match, vertex read, compare
      // and write
      other_vld_r <= rel_in && ({1'b0, ea} == pick_r || {1'b0, eb} == pick_r);
      other_r     <= ({1'b0, ea} == pick_r) ? eb[AV-1:0] : ea[AV-1:0];
      other_w_r   <= ew;
      cmp_vld_r   <= other_vld_r;
      cmp_v_r     <= other_r;
      cmp_w_r     <= other_w_r;
      upd_vld_r   <= relax_hit;
      upd_v_r     <= cmp_v_r;
      upd_w_r     <= cmp_w_r;
      if (cmd.clear) begin
        ecount_r <= '0;
        wsum_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_r.tree_weight  <= tree_sat;
      result_r.total_weight <= wsum_r;
      result_r.saved_weight <= (wsum_r >= tree_sat) ? wsum_r - tree_sat : '0;
      result_r.connected    <= (reached_r == n_r);
    end
  end

  assign result         = result_r;
  assign sts.init_last  = (vidx_r == n_r - NV'(1));
  assign sts.scan_last  = (vidx_r == n_r - NV'(1));
  assign sts.found      = (best_v_r != n_r);
  assign sts.relax_last = (eidx_r == ecount_r - NE'(1));
  assign sts.no_edges   = (ecount_r == '0);

endmodule

// File: src/mstw_ctrl.sv
// ----------------------------------------------------------------------------
// mstw_ctrl : sequencer of the spanning tree walk
// Runs load, init sweep, pick scan and relax sweep; holds the result.
// ----------------------------------------------------------------------------
module mstw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 last_edge,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mstw_pkg::mstw_sts_t  sts,
  output mstw_pkg::mstw_cmd_t  cmd
);
  import mstw_pkg::*;

  mstw_state_t state_r, state_nxt;
  logic [2:0]  drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    case (state_r)
      ST_LOAD:  if (in_valid && last_edge) state_nxt = ST_INIT;
      ST_INIT:  if (sts.init_last) state_nxt = ST_SCAN;
      ST_SCAN: begin
        drain_nxt = 3'd2;
        if (sts.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        drain_nxt = drain_r - 3'd1;
        if (drain_r == 3'd1) state_nxt = ST_PICK;
      end
      ST_PICK: state_nxt = !sts.found ? ST_DONE :
                           (sts.no_edges ? ST_SCAN : ST_RELAX);
      ST_RELAX: begin
        drain_nxt = 3'd5;
        if (sts.relax_last) state_nxt = ST_RELAX_END;
      end
      ST_RELAX_END: begin
        drain_nxt = drain_r - 3'd1;
        if (drain_r == 3'd1) state_nxt = ST_SCAN;
      end
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = (state_r == ST_LOAD);
    out_valid   = (state_r == ST_OUT);
    case (state_r)
      ST_LOAD: begin
        cmd.load       = in_valid;
        cmd.init_start = in_valid && last_edge;
      end
      ST_INIT: begin
        cmd.init_step  = 1'b1;
        cmd.scan_start = sts.init_last;
      end
      ST_SCAN:      cmd.scan_step = 1'b1;
      ST_SCAN_END:  ;
      ST_PICK: begin
        cmd.pick        = sts.found;
        cmd.relax_start = 1'b1;
        cmd.scan_start  = sts.found && sts.no_edges;
      end
      ST_RELAX:     cmd.relax_step = 1'b1;
      ST_RELAX_END: cmd.scan_start = (drain_r == 3'd1);
      ST_DONE: begin
        cmd.finish = 1'b1;
        cmd.clear  = 1'b1;
      end
      ST_OUT:  ;
      default: ;
    endcase
  end

endmodule
